@@ src/assert_macros.svh @@
// assertion macros used by the checker file mh2_checker.sv
// depends on nothing; every macro samples on the rising edge and is off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every sampled edge
`define MH2_ASSERT_ALWAYS(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("mh2 check failed");

// same-cycle implication
`define MH2_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mh2 check failed");

// next-cycle implication
`define MH2_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mh2 check failed");

`endif

@@ src/mh2_pkg.sv @@
// shared types, constants and codes of the streaming murmurhash2 engine
// depends on nothing
package mh2_pkg;

	// hash constants
	localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
	localparam int          MIX_SHIFT   = 24;
	localparam int          FIN_SHIFT_A = 13;
	localparam int          FIN_SHIFT_B = 15;

	// configuration port
	localparam int         CFG_AW       = 3;
	localparam logic       REG_KEY_SEED = 1'b0;

	// queue sizes
	localparam int OPQ_DEPTH = 2;
	localparam int OPQ_AW    = $clog2(OPQ_DEPTH);
	localparam int OPQ_CW    = $clog2(OPQ_DEPTH + 1);
	localparam int RQ_DEPTH  = 2;
	localparam int RQ_AW     = $clog2(RQ_DEPTH);
	localparam int RQ_CW     = $clog2(RQ_DEPTH + 1);

	// what the back end does with one word
	typedef enum logic [1:0] {
		KIND_FULL = 2'd0,
		KIND_TAIL = 2'd1,
		KIND_NONE = 2'd2
	} kind_t;

	// one classified word on its way to the back end
	typedef struct packed {
		kind_t       kind;
		logic [31:0] word;
		logic        first;
		logic        last;
		logic [31:0] init;
	} op_t;

	// queue status seen by the back end
	typedef struct packed {
		logic empty;
		op_t  op;
	} opq_view_t;

endpackage

@@ src/mh2_cfg.sv @@
// apb-style register file holding the hash seed
// depends on mh2_pkg
module mh2_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [mh2_pkg::CFG_AW-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	output logic [31:0]                key_seed
);

	logic [31:0] seed_q;
	logic        wr_seed;

	// write decode on the access phase
	assign wr_seed = psel && penable && pwrite && (paddr[2] == mh2_pkg::REG_KEY_SEED);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (wr_seed) begin
			seed_q <= pwdata;
		end
	end

	// read mux
	assign prdata   = (paddr[2] == mh2_pkg::REG_KEY_SEED) ? seed_q : 32'd0;
	assign pready   = 1'b1;
	assign key_seed = seed_q;

endmodule

@@ src/mh2_front.sv @@
// front end: classifies an incoming key word into a back-end operation
// depends on mh2_pkg
module mh2_front (
	input  logic [31:0]      key_word,
	input  logic [2:0]       valid_bytes,
	input  logic             first_word,
	input  logic             last_word,
	input  logic [15:0]      total_length,
	input  logic [31:0]      key_seed,
	output mh2_pkg::op_t     op
);

	logic full_word;
	logic [31:0] tail_mask;

	// a word counts as full unless it is last and carries fewer than four bytes
	assign full_word = !last_word || valid_bytes[2];

	// tail byte mask
	always_comb begin
		case (valid_bytes[1:0])
			2'd1:    tail_mask = 32'h0000_00ff;
			2'd2:    tail_mask = 32'h0000_ffff;
			2'd3:    tail_mask = 32'h00ff_ffff;
			default: tail_mask = 32'h0000_0000;
		endcase
	end

	// build the operation
	always_comb begin
		op.first = first_word;
		op.last  = last_word;
		op.init  = key_seed ^ {16'd0, total_length};
		if (full_word) begin
			op.kind = mh2_pkg::KIND_FULL;
			op.word = key_word;
		end else if (valid_bytes[1:0] == 2'd0) begin
			op.kind = mh2_pkg::KIND_NONE;
			op.word = 32'd0;
		end else begin
			op.kind = mh2_pkg::KIND_TAIL;
			op.word = key_word & tail_mask;
		end
	end

endmodule

@@ src/mh2_opq.sv @@
// short operation queue between front and back end
// depends on mh2_pkg
module mh2_opq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr,
	input  mh2_pkg::op_t       wr_op,
	output logic               full,
	input  logic               rd,
	output mh2_pkg::opq_view_t view
);

	mh2_pkg::op_t                 mem_q [mh2_pkg::OPQ_DEPTH];
	logic [mh2_pkg::OPQ_AW-1:0]   wr_ptr_q;
	logic [mh2_pkg::OPQ_AW-1:0]   rd_ptr_q;
	logic [mh2_pkg::OPQ_CW-1:0]   count_q;
	logic                         do_wr;
	logic                         do_rd;

	assign full  = (count_q == mh2_pkg::OPQ_CW'(mh2_pkg::OPQ_DEPTH));
	assign do_wr = wr && !full;
	assign do_rd = rd && (count_q != '0);

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_op;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == mh2_pkg::OPQ_AW'(mh2_pkg::OPQ_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == mh2_pkg::OPQ_AW'(mh2_pkg::OPQ_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign view.empty = (count_q == '0);
	assign view.op    = mem_q[rd_ptr_q];

endmodule

@@ src/mh2_back.sv @@
// back end: mixes words into the running hash, finalises and queues results
// depends on mh2_pkg
module mh2_back (
	input  logic               clk,
	input  logic               arst_n,
	input  mh2_pkg::opq_view_t view,
	output logic               opq_rd,
	output logic               empty,
	input  logic               pop,
	output logic [31:0]        hash_value
);

	localparam logic [1:0] S_MIX1 = 2'd0;
	localparam logic [1:0] S_MIX2 = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;

	logic [1:0]  state_q;
	logic [31:0] h_q;
	logic [31:0] k1_q;
	logic [31:0] hm_q;
	logic        last_q;

	logic [31:0] h_start;
	logic [31:0] mul_a_in;
	logic [31:0] mul_b_in;
	logic [31:0] mul_a_p;
	logic [31:0] mul_b_p;
	logic [31:0] fin_hash;

	logic [31:0]               rq_mem_q [mh2_pkg::RQ_DEPTH];
	logic [mh2_pkg::RQ_AW-1:0] rq_wr_ptr_q;
	logic [mh2_pkg::RQ_AW-1:0] rq_rd_ptr_q;
	logic [mh2_pkg::RQ_CW-1:0] rq_count_q;
	logic                      rq_full;
	logic                      rq_wr;
	logic                      rq_rd;

	// operand selection for the two multipliers
	always_comb begin
		h_start  = view.op.first ? view.op.init : h_q;
		mul_a_in = view.op.word;
		mul_b_in = h_start;
		case (state_q)
			S_MIX1: begin
				mul_a_in = view.op.word;
				mul_b_in = (view.op.kind == mh2_pkg::KIND_TAIL) ?
					(h_start ^ view.op.word) : h_start;
			end
			S_MIX2: begin
				mul_a_in = k1_q ^ (k1_q >> mh2_pkg::MIX_SHIFT);
			end
			S_FIN: begin
				mul_a_in = h_q ^ (h_q >> mh2_pkg::FIN_SHIFT_A);
			end
			default: begin
				mul_a_in = view.op.word;
			end
		endcase
	end

	// constant multipliers, low 32 bits kept
	assign mul_a_p  = mul_a_in * mh2_pkg::MIX_MUL;
	assign mul_b_p  = mul_b_in * mh2_pkg::MIX_MUL;
	assign fin_hash = mul_a_p ^ (mul_a_p >> mh2_pkg::FIN_SHIFT_B);

	assign opq_rd = (state_q == S_MIX1) && !view.empty;
	assign rq_wr  = (state_q == S_FIN) && !rq_full;

	// mixing sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_MIX1;
			h_q     <= '0;
			last_q  <= 1'b0;
		end else begin
			case (state_q)
				S_MIX1: begin
					if (!view.empty) begin
						last_q <= view.op.last;
						case (view.op.kind)
							mh2_pkg::KIND_FULL: begin
								state_q <= S_MIX2;
							end
							mh2_pkg::KIND_TAIL: begin
								h_q     <= mul_b_p;
								state_q <= view.op.last ? S_FIN : S_MIX1;
							end
							default: begin
								h_q     <= h_start;
								state_q <= view.op.last ? S_FIN : S_MIX1;
							end
						endcase
					end
				end
				S_MIX2: begin
					h_q     <= hm_q ^ mul_a_p;
					state_q <= last_q ? S_FIN : S_MIX1;
				end
				S_FIN: begin
					if (!rq_full) begin
						state_q <= S_MIX1;
					end
				end
				default: begin
					state_q <= S_MIX1;
				end
			endcase
		end
	end

	// first-stage products of a full word
	always_ff @(posedge clk) begin
		if (state_q == S_MIX1) begin
			k1_q <= mul_a_p;
			hm_q <= mul_b_p;
		end
	end

	// result queue storage
	always_ff @(posedge clk) begin
		if (rq_wr) begin
			rq_mem_q[rq_wr_ptr_q] <= fin_hash;
		end
	end

	assign rq_full = (rq_count_q == mh2_pkg::RQ_CW'(mh2_pkg::RQ_DEPTH));
	assign empty   = (rq_count_q == '0);
	assign rq_rd   = pop && !empty;

	// result queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rq_wr_ptr_q <= '0;
			rq_rd_ptr_q <= '0;
			rq_count_q  <= '0;
		end else begin
			if (rq_wr) begin
				rq_wr_ptr_q <= (rq_wr_ptr_q == mh2_pkg::RQ_AW'(mh2_pkg::RQ_DEPTH - 1)) ?
					'0 : rq_wr_ptr_q + 1'b1;
			end
			if (rq_rd) begin
				rq_rd_ptr_q <= (rq_rd_ptr_q == mh2_pkg::RQ_AW'(mh2_pkg::RQ_DEPTH - 1)) ?
					'0 : rq_rd_ptr_q + 1'b1;
			end
			if (rq_wr && !rq_rd) begin
				rq_count_q <= rq_count_q + 1'b1;
			end else if (rq_rd && !rq_wr) begin
				rq_count_q <= rq_count_q - 1'b1;
			end
		end
	end

	assign hash_value = rq_mem_q[rq_rd_ptr_q];

endmodule

@@ src/murmur2_hash_stream.sv @@
// channel   direction  handshake        payload
// config    in         psel/penable     paddr, pwdata -> prdata (key_seed at 0x0)
// key beat  in         push / full      key_word, valid_bytes, first_word, last_word,
//                                       total_length
// hash beat out        pop / empty      hash_value
//
// a full word passes the back end in S_MIX1 (word multiply), then S_MIX2 (mix multiply);
// a tail word and an empty last word pass in S_MIX1 only; the last word of a key adds
// S_FIN for the final multiply. the back end's multiply chain sets the rate.
// reset clears queues, sequencer, running hash and seed; no clearing pass.
// a stalled hash beat holds the back end only once its 2-entry result queue is
// full; key beats keep entering until the 2-entry operation queue fills.
// top level of the streaming murmurhash2 engine
// depends on mh2_pkg, mh2_cfg, mh2_front, mh2_opq, mh2_back
module murmur2_hash_stream (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [mh2_pkg::CFG_AW-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	input  logic                       push,
	output logic                       full,
	input  logic [31:0]                key_word,
	input  logic [2:0]                 valid_bytes,
	input  logic                       first_word,
	input  logic                       last_word,
	input  logic [15:0]                total_length,
	output logic                       empty,
	input  logic                       pop,
	output logic [31:0]                hash_value
);

	logic               [31:0] key_seed;
	mh2_pkg::op_t              front_op;
	mh2_pkg::opq_view_t        opq_view;
	logic                      opq_rd;

	// configuration registers
	mh2_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.key_seed  (key_seed)
	);

	// classify incoming beats
	mh2_front u_front (
		.key_word     (key_word),
		.valid_bytes  (valid_bytes),
		.first_word   (first_word),
		.last_word    (last_word),
		.total_length (total_length),
		.key_seed     (key_seed),
		.op           (front_op)
	);

	// decoupling queue
	mh2_opq u_opq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (push),
		.wr_op  (front_op),
		.full   (full),
		.rd     (opq_rd),
		.view   (opq_view)
	);

	// mixing and finalisation
	mh2_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.view       (opq_view),
		.opq_rd     (opq_rd),
		.empty      (empty),
		.pop        (pop),
		.hash_value (hash_value)
	);

endmodule

@@ src/mh2_checker.sv @@
// port-level checks for the streaming murmurhash2 engine, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"

module mh2_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pready,
	input  logic        push,
	input  logic        full,
	input  logic        empty,
	input  logic        pop,
	input  logic [31:0] hash_value
);

	// register port never waits
	`MH2_ASSERT_ALWAYS(a_pready_high, clk, arst_n, pready)

	// a waiting hash beat holds until taken
	`MH2_ASSERT_NEXT(a_hash_held, clk, arst_n, !empty && !pop, !empty && $stable(hash_value))

	// the operation queue only fills through an accepted key beat
	`MH2_ASSERT_IMPL(a_full_needs_push, clk, arst_n, $rose(full), $past(push && !full))

	// the result queue only drains through a pop
	`MH2_ASSERT_IMPL(a_empty_needs_pop, clk, arst_n, $rose(empty), $past(pop))

endmodule

bind murmur2_hash_stream mh2_checker u_mh2_checker (.*);

@@ bench/tb_top.sv @@
// self-checking bench for the streaming murmurhash2 engine: directed keys, then random keys
// under several seeds, each hash checked against an in-bench predictor
// depends on mh2_pkg and murmur2_hash_stream
module tb_top;

	localparam logic [31:0] HASH_MUL = 32'h5bd1e995;
	localparam logic [mh2_pkg::CFG_AW-1:0] SEED_ADDR =
		mh2_pkg::CFG_AW'(4 * mh2_pkg::REG_KEY_SEED);
	localparam int PHASES = 5;
	localparam int PHASE_BEATS = 270;
	localparam int SETTLE_CYCLES = 10;

	typedef struct {
		logic [31:0] word;
		logic [2:0]  nbytes;
		logic        first;
		logic        last;
		logic [15:0] len;
	} key_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [mh2_pkg::CFG_AW-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        push = 1'b0;
	logic        full;
	logic [31:0] key_word = '0;
	logic [2:0]  valid_bytes = '0;
	logic        first_word = 1'b0;
	logic        last_word = 1'b0;
	logic [15:0] total_length = '0;
	logic        empty;
	logic        pop = 1'b0;
	logic [31:0] hash_value;

	key_beat_t   key_beats[$];
	logic [31:0] hash_due[$];
	logic [31:0] seed_shadow = '0;
	logic [31:0] hash_acc = '0;
	bit          calm = 1'b0;
	int          errors = 0;
	int          send_gap = 0;
	int          pop_gap = 0;

	murmur2_hash_stream dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.push(push), .full(full),
		.key_word(key_word), .valid_bytes(valid_bytes), .first_word(first_word),
		.last_word(last_word), .total_length(total_length),
		.empty(empty), .pop(pop), .hash_value(hash_value)
	);

	// clock and reset
	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	// watchdog
	initial begin
		#5000000;
		$display("** murmur2_hash_stream: FAILED **");
		$finish;
	end

	// one full word: mix the word, then fold it into the running hash
	function automatic logic [31:0] fold_full(logic [31:0] h, logic [31:0] k);
		k = k * HASH_MUL;
		k = k ^ (k >> 24);
		k = k * HASH_MUL;
		return (h * HASH_MUL) ^ k;
	endfunction

	// final avalanche on the running hash
	function automatic logic [31:0] finish_hash(logic [31:0] h);
		h = h ^ (h >> 13);
		h = h * HASH_MUL;
		return h ^ (h >> 15);
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 7))
			0: return 32'h0;
			1: return 32'hffffffff;
			default: return $urandom;
		endcase
	endfunction

	function automatic void add_beat(logic [31:0] word, logic [2:0] nbytes, logic first,
			logic last, logic [15:0] len);
		key_beat_t b;
		b.word = word;
		b.nbytes = nbytes;
		b.first = first;
		b.last = last;
		b.len = len;
		key_beats.push_back(b);
	endfunction

	// one random key, mostly well formed; returns the number of beats queued
	function automatic int add_key();
		int klen;
		int nwords;
		logic [2:0] nb;
		logic [15:0] len_field;
		bit drop_first;
		klen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 200) : $urandom_range(0, 24);
		nwords = (klen == 0) ? 1 : (klen + 3) / 4;
		len_field = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'(klen);
		drop_first = ($urandom_range(0, 19) == 0);
		for (int i = 0; i < nwords; i++) begin
			if (i == nwords - 1) begin
				nb = (klen == 0) ? 3'd0 : ((klen % 4 == 0) ? 3'd4 : 3'(klen % 4));
				if ($urandom_range(0, 15) == 0)
					nb = 3'($urandom_range(0, 7));
			end else begin
				nb = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
			end
			add_beat(rand_word(), nb, (i == 0) && !drop_first, i == nwords - 1, len_field);
		end
		return nwords;
	endfunction

	// configuration writes and read-back, only while the engine is idle
	task automatic seed_write(logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= SEED_ADDR;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		seed_shadow = value;
	endtask

	task automatic seed_check();
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= SEED_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== seed_shadow) begin
			$error("key_seed read: expected %h, actual %h", seed_shadow, prdata);
			errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// hold off until every queued beat is in and every hash is out
	task automatic drain();
		while (key_beats.size() != 0 || push || hash_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// key beat driver
	always @(posedge clk or negedge arst_n) begin : key_driver
		key_beat_t b;
		if (!arst_n) begin
			push <= 1'b0;
			send_gap <= 0;
		end else if (!push || !full) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				push <= 1'b0;
			end else if (key_beats.size() != 0 && !calm && $urandom_range(0, 7) == 0) begin
				send_gap <= $urandom_range(0, 3);
				push <= 1'b0;
			end else if (key_beats.size() != 0) begin
				b = key_beats.pop_front();
				push <= 1'b1;
				key_word <= b.word;
				valid_bytes <= b.nbytes;
				first_word <= b.first;
				last_word <= b.last;
				total_length <= b.len;
			end else begin
				push <= 1'b0;
			end
		end
	end

	// hash beat stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
			pop_gap <= 0;
		end else if (pop_gap > 0) begin
			pop_gap <= pop_gap - 1;
			pop <= 1'b0;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			pop_gap <= $urandom_range(0, 3);
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
		end
	end

	// predict the running hash on every accepted key beat
	always @(posedge clk) begin : hash_predictor
		logic [31:0] h;
		if (arst_n && push && !full) begin
			h = first_word ? (seed_shadow ^ {16'h0, total_length}) : hash_acc;
			if (!last_word || valid_bytes >= 3'd4)
				h = fold_full(h, key_word);
			else if (valid_bytes != 3'd0)
				h = (h ^ (key_word & ((valid_bytes == 3'd1) ? 32'h000000ff :
					(valid_bytes == 3'd2) ? 32'h0000ffff : 32'h00ffffff))) * HASH_MUL;
			hash_acc = h;
			if (last_word)
				hash_due.push_back(finish_hash(h));
		end
	end

	// compare each accepted hash beat with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (hash_due.size() == 0) begin
				$error("hash_value: none expected, actual %h", hash_value);
				errors++;
			end else if (hash_value !== hash_due[0]) begin
				$error("hash_value: expected %h, actual %h", hash_due[0], hash_value);
				errors++;
				void'(hash_due.pop_front());
			end else begin
				void'(hash_due.pop_front());
			end
		end
	end

	// stimulus
	initial begin
		int sent;
		logic [31:0] seed;
		while (!arst_n) @(posedge clk);

		// directed: continuing after reset, empty key, tails, oversize counts, restarts
		add_beat(32'h000000a5, 3'd4, 1'b0, 1'b1, 16'h0000);
		add_beat(32'hffffffff, 3'd0, 1'b1, 1'b1, 16'h0000);
		add_beat(32'hffffffff, 3'd1, 1'b1, 1'b1, 16'h0001);
		add_beat(32'hffffffff, 3'd2, 1'b1, 1'b1, 16'h0002);
		add_beat(32'hffffffff, 3'd3, 1'b1, 1'b1, 16'h0003);
		add_beat(32'h00000000, 3'd4, 1'b1, 1'b1, 16'h0004);
		add_beat(32'h12345678, 3'd5, 1'b1, 1'b1, 16'hffff);
		add_beat(32'h9abcdef0, 3'd6, 1'b1, 1'b1, 16'hffff);
		add_beat(32'hdeadbeef, 3'd7, 1'b1, 1'b1, 16'hffff);
		add_beat(32'h03020100, 3'd4, 1'b1, 1'b0, 16'd11);
		add_beat(32'hffffffff, 3'd0, 1'b0, 1'b0, 16'd0);
		add_beat(32'h000a0908, 3'd3, 1'b0, 1'b1, 16'd0);
		add_beat(32'h11111111, 3'd4, 1'b1, 1'b0, 16'd8);
		add_beat(32'h22222222, 3'd4, 1'b1, 1'b0, 16'd8);
		add_beat(32'h33333333, 3'd2, 1'b0, 1'b1, 16'd0);
		add_beat(32'h44444444, 3'd1, 1'b0, 1'b1, 16'd0);
		add_beat(32'hffffffff, 3'd7, 1'b1, 1'b0, 16'hffff);
		add_beat(32'h80000000, 3'd4, 1'b0, 1'b1, 16'h8000);
		drain();
		seed_check();

		// random keys under several seeds, extremes first, last phase without idling
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: seed = 32'hffffffff;
				1: seed = 32'h00000000;
				2: seed = 32'h80000001;
				default: seed = $urandom;
			endcase
			seed_write(seed);
			seed_check();
			calm = (p == PHASES - 1);
			sent = 0;
			while (sent < PHASE_BEATS) begin
				if ($urandom_range(0, 9) == 0) begin
					add_beat($urandom, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)), 16'($urandom));
					sent++;
				end else begin
					sent += add_key();
				end
			end
			drain();
		end

		if (errors == 0 && hash_due.size() == 0)
			$display("** murmur2_hash_stream: PASSED **");
		else
			$display("** murmur2_hash_stream: FAILED **");
		$finish;
	end

endmodule
